@@ rtl/core/nsca_pkg.sv @@
package nsca_pkg;

  localparam int COORD_BITS    = 16;
  localparam int MAX_IMAGE_DIM = 4096;
  // quotient bits of the per-pixel scale division, one per cell
  localparam int DIV_STEPS     = 12;
  localparam int PROD_BITS     = 28;

  typedef logic signed [33:0] sval_t;

  typedef enum logic [2:0] {
    REG_SRC_SIZE   = 3'd0,
    REG_DST_SIZE   = 3'd1,
    REG_SRC_ORG    = 3'd2,
    REG_SRC_EXT    = 3'd3,
    REG_DST_ORG    = 3'd4,
    REG_DST_EXT    = 3'd5,
    REG_CLIP_ORG   = 3'd6,
    REG_CLIP_EXT   = 3'd7
  } cfg_reg_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_LOAD,
    ST_CHK,
    ST_CLIP1,
    ST_CLIP2,
    ST_CLIP3,
    ST_CLIP4,
    ST_CHK2,
    ST_MUL1,
    ST_DIV1,
    ST_SHR1,
    ST_OVR,
    ST_MUL2,
    ST_DIV2,
    ST_SHR2,
    ST_POST1,
    ST_POST2,
    ST_POST3,
    ST_POST4,
    ST_POST5,
    ST_STORE
  } setup_state_e;

  typedef struct packed {
    logic [12:0]        lo;
    logic [12:0]        hi;
    logic signed [16:0] dpos;
    logic [14:0]        dext;
    logic [11:0]        spos;
    logic [12:0]        sext;
  } axis_geo_t;

  typedef struct packed {
    logic      ok;
    axis_geo_t x;
    axis_geo_t y;
    logic [12:0] src_w;
  } geo_t;

  typedef struct packed {
    logic                  vld;
    logic                  ok;
    logic [PROD_BITS-1:0]  rem_x;
    logic [DIV_STEPS-1:0]  quo_x;
    logic [PROD_BITS-1:0]  rem_y;
    logic [DIV_STEPS-1:0]  quo_y;
  } div_cell_t;

  function automatic sval_t coord_f(input logic [15:0] h);
    return sval_t'($signed(h[COORD_BITS-1:0]));
  endfunction

  function automatic sval_t dim_f(input logic [15:0] h);
    sval_t v;
    v = sval_t'({1'b0, h});
    return (v > sval_t'(MAX_IMAGE_DIM)) ? sval_t'(MAX_IMAGE_DIM) : v;
  endfunction

endpackage

@@ rtl/core/nsca_div_cell.sv @@
module nsca_div_cell import nsca_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic [PROD_BITS-1:0] den_x_i,
  input  logic [PROD_BITS-1:0] den_y_i,
  input  div_cell_t            cell_i,
  output div_cell_t            cell_o
);

  div_cell_t cell_d, cell_q;
  logic      bit_x, bit_y;

  // one restoring step per axis; divisors arrive pre-shifted for this bit
  always_comb begin
    cell_d = cell_i;
    bit_x  = (cell_i.rem_x >= den_x_i);
    bit_y  = (cell_i.rem_y >= den_y_i);
    if (bit_x) begin
      cell_d.rem_x = cell_i.rem_x - den_x_i;
    end
    if (bit_y) begin
      cell_d.rem_y = cell_i.rem_y - den_y_i;
    end
    cell_d.quo_x = {cell_i.quo_x[DIV_STEPS-2:0], bit_x};
    cell_d.quo_y = {cell_i.quo_y[DIV_STEPS-2:0], bit_y};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

@@ rtl/core/nsca_setup.sv @@
module nsca_setup import nsca_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [32:0] cfg_data_i,
  output logic        busy_o,
  output geo_t        geo_o
);

  logic [31:0] src_size_q, dst_size_q, src_org_q, src_ext_q;
  logic [31:0] dst_org_q, dst_ext_q, clip_org_q;
  logic [32:0] clip_ext_q;

  setup_state_e state_q, state_d;
  logic  ax_q, ax_d;
  logic  fail_q, fail_d, fail_now;
  logic  neg_q, neg_d;
  sval_t c_q, c_d, w_q, w_d, dp_q, dp_d, de_q, de_d;
  sval_t sp_q, sp_d, se_q, se_d, simg_q, simg_d, dimg_q, dimg_d;
  logic [15:0] rem_q, rem_d;
  logic [31:0] quo_q, quo_d;
  logic [4:0]  cnt_q, cnt_d;
  axis_geo_t   gx_q, gy_q, g_new;
  logic        okx_q, oky_q;

  logic [15:0] h_ssz, h_dsz, h_sorg, h_sext, h_dorg, h_dext, h_corg, h_cext;
  logic        use_clip;
  logic signed [16:0] ma, mb;
  sval_t prod, mag, qv, cw, span_hi;
  logic [16:0] r17, d17;
  logic        dbit;

  function automatic logic meet(input sval_t a, input sval_t aw, input sval_t b,
                                input sval_t bw);
    return !((a + aw <= b) || (b + bw <= a));
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_size_q <= '0;
      dst_size_q <= '0;
      src_org_q  <= '0;
      src_ext_q  <= '0;
      dst_org_q  <= '0;
      dst_ext_q  <= '0;
      clip_org_q <= '0;
      clip_ext_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_SRC_SIZE: src_size_q <= cfg_data_i[31:0];
        REG_DST_SIZE: dst_size_q <= cfg_data_i[31:0];
        REG_SRC_ORG:  src_org_q  <= cfg_data_i[31:0];
        REG_SRC_EXT:  src_ext_q  <= cfg_data_i[31:0];
        REG_DST_ORG:  dst_org_q  <= cfg_data_i[31:0];
        REG_DST_EXT:  dst_ext_q  <= cfg_data_i[31:0];
        REG_CLIP_ORG: clip_org_q <= cfg_data_i[31:0];
        REG_CLIP_EXT: clip_ext_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // axis 0 takes the upper halves, axis 1 the lower
  always_comb begin
    h_ssz    = ax_q ? src_size_q[15:0] : src_size_q[31:16];
    h_dsz    = ax_q ? dst_size_q[15:0] : dst_size_q[31:16];
    h_sorg   = ax_q ? src_org_q[15:0]  : src_org_q[31:16];
    h_sext   = ax_q ? src_ext_q[15:0]  : src_ext_q[31:16];
    h_dorg   = ax_q ? dst_org_q[15:0]  : dst_org_q[31:16];
    h_dext   = ax_q ? dst_ext_q[15:0]  : dst_ext_q[31:16];
    h_corg   = ax_q ? clip_org_q[15:0] : clip_org_q[31:16];
    h_cext   = ax_q ? clip_ext_q[15:0] : clip_ext_q[31:16];
    use_clip = clip_ext_q[32];
  end

  always_comb begin
    case (state_q)
      ST_CHK:   fail_now = (de_q <= 0) || !meet(dp_q, de_q, '0, dimg_q)
                           || !meet(sp_q, se_q, '0, simg_q);
      ST_CHK2:  fail_now = (se_q <= 0) || (w_q <= 0);
      ST_OVR:   fail_now = (sp_q >= simg_q) || (de_q <= 0) || (se_q <= 0);
      ST_POST2: fail_now = (w_q <= 0) || (c_q >= dimg_q);
      ST_POST5: fail_now = (w_q <= 0);
      default:  fail_now = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    case (state_q)
      ST_IDLE:  state_d = ST_IDLE;
      ST_LOAD:  state_d = ST_CHK;
      ST_CHK:   state_d = fail_now ? ST_STORE : ST_CLIP1;
      ST_CLIP1: state_d = ST_CLIP2;
      ST_CLIP2: state_d = ST_CLIP3;
      ST_CLIP3: state_d = ST_CLIP4;
      ST_CLIP4: state_d = ST_CHK2;
      ST_CHK2:  state_d = fail_now ? ST_STORE : ((sp_q < 0) ? ST_MUL1 : ST_OVR);
      ST_MUL1:  state_d = ST_DIV1;
      ST_DIV1:  state_d = (&cnt_q) ? ST_SHR1 : ST_DIV1;
      ST_SHR1:  state_d = ST_OVR;
      ST_OVR:   state_d = fail_now ? ST_STORE :
                          ((sp_q + se_q > simg_q) ? ST_MUL2 : ST_POST1);
      ST_MUL2:  state_d = ST_DIV2;
      ST_DIV2:  state_d = (&cnt_q) ? ST_SHR2 : ST_DIV2;
      ST_SHR2:  state_d = ST_POST1;
      ST_POST1: state_d = ST_POST2;
      ST_POST2: state_d = fail_now ? ST_STORE : ST_POST3;
      ST_POST3: state_d = ST_POST4;
      ST_POST4: state_d = ST_POST5;
      ST_POST5: state_d = ST_STORE;
      ST_STORE: state_d = ax_q ? ST_IDLE : ST_LOAD;
      default:  state_d = ST_IDLE;
    endcase
    if (cfg_we_i) begin
      state_d = ST_LOAD;
    end
  end

  // datapath
  always_comb begin
    c_d = c_q; w_d = w_q; dp_d = dp_q; de_d = de_q;
    sp_d = sp_q; se_d = se_q; simg_d = simg_q; dimg_d = dimg_q;
    rem_d = rem_q; quo_d = quo_q; cnt_d = cnt_q; neg_d = neg_q;
    ax_d = ax_q;
    fail_d = fail_q | fail_now;

    ma = (state_q == ST_MUL1) ? sp_q[16:0] : de_q[16:0];
    cw = simg_q - sp_q;
    mb = (state_q == ST_MUL1) ? de_q[16:0] : cw[16:0];
    prod = sval_t'(ma) * sval_t'(mb);
    mag  = (prod < 0) ? -prod : prod;

    r17  = {rem_q, quo_q[31]};
    d17  = {1'b0, se_q[15:0]};
    dbit = (r17 >= d17);

    qv = neg_q ? -sval_t'({2'b00, quo_q}) : sval_t'({2'b00, quo_q});

    case (state_q)
      ST_LOAD: begin
        simg_d = dim_f(h_ssz);
        dimg_d = dim_f(h_dsz);
        sp_d   = coord_f(h_sorg);
        se_d   = coord_f(h_sext);
        dp_d   = coord_f(h_dorg);
        de_d   = coord_f(h_dext);
        c_d    = use_clip ? coord_f(h_corg) : '0;
        w_d    = use_clip ? coord_f(h_cext) : dim_f(h_dsz);
        fail_d = 1'b0;
      end
      ST_CLIP1: begin
        if (use_clip && (c_q < 0)) begin
          w_d = w_q + c_q;
          c_d = '0;
        end
      end
      ST_CLIP2: begin
        if (use_clip && (c_q + w_q > dimg_q)) begin
          w_d = dimg_q - c_q;
        end
      end
      ST_CLIP3, ST_POST2: begin
        if (c_q < dp_q) begin
          w_d = w_q + c_q - dp_q;
          c_d = dp_q;
        end
      end
      ST_CLIP4, ST_POST4: begin
        if (c_q + w_q > dp_q + de_q) begin
          w_d = dp_q + de_q - c_q;
        end
      end
      ST_MUL1, ST_MUL2: begin
        quo_d = mag[31:0];
        rem_d = '0;
        cnt_d = '0;
        neg_d = (prod < 0);
      end
      ST_DIV1, ST_DIV2: begin
        rem_d = dbit ? 16'(r17 - d17) : r17[15:0];
        quo_d = {quo_q[30:0], dbit};
        cnt_d = cnt_q + 5'd1;
      end
      ST_SHR1: begin
        dp_d = dp_q - qv;
        de_d = de_q + qv;
        se_d = se_q + sp_q;
        sp_d = '0;
      end
      ST_SHR2: begin
        de_d = qv;
        se_d = simg_q - sp_q;
      end
      ST_POST1: begin
        if (c_q < 0) begin
          w_d = w_q + c_q;
          c_d = '0;
        end
      end
      ST_POST3: begin
        if (c_q + w_q > dimg_q) begin
          w_d = dimg_q - c_q;
        end
      end
      ST_STORE: begin
        ax_d = 1'b1;
      end
      default: ;
    endcase
    if (cfg_we_i) begin
      ax_d = 1'b0;
    end
  end

  always_comb begin
    span_hi    = c_q + w_q;
    g_new.lo   = c_q[12:0];
    g_new.hi   = span_hi[12:0];
    g_new.dpos = dp_q[16:0];
    g_new.dext = de_q[14:0];
    g_new.spos = sp_q[11:0];
    g_new.sext = se_q[12:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ax_q    <= 1'b0;
      fail_q  <= 1'b0;
      okx_q   <= 1'b0;
      oky_q   <= 1'b0;
      cnt_q   <= '0;
      neg_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      ax_q    <= ax_d;
      fail_q  <= fail_d;
      cnt_q   <= cnt_d;
      neg_q   <= neg_d;
      if (state_q == ST_STORE) begin
        if (ax_q) begin
          oky_q <= !fail_q;
        end else begin
          okx_q <= !fail_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    c_q <= c_d; w_q <= w_d; dp_q <= dp_d; de_q <= de_d;
    sp_q <= sp_d; se_q <= se_d; simg_q <= simg_d; dimg_q <= dimg_d;
    rem_q <= rem_d; quo_q <= quo_d;
    if (state_q == ST_STORE) begin
      if (ax_q) begin
        gy_q <= g_new;
      end else begin
        gx_q <= g_new;
      end
    end
  end

  logic [15:0] src_w_full;
  sval_t       src_w_dim;

  always_comb begin
    src_w_full  = src_size_q[31:16];
    src_w_dim   = dim_f(src_w_full);
    geo_o.ok    = okx_q & oky_q;
    geo_o.x     = gx_q;
    geo_o.y     = gy_q;
    geo_o.src_w = src_w_dim[12:0];
  end

  assign busy_o = (state_q != ST_IDLE) || cfg_we_i;

endmodule

@@ rtl/core/nearest_scale_clip_address.sv @@
// Nearest-neighbor scaling address generator. Takes a destination pixel and returns
// whether it is drawn and its source column, row and linear address (row * source
// width + column). Throughput is one item per clock while neither in_stall_o nor
// out_stall_i holds the flow; the per-pixel scale division runs through a chain of 12
// cells, one quotient bit each. Any configuration write starts a geometry pass that
// stalls input while it runs, two axes in turn, with an iterative 32-step divider for
// the source region shrink. Writing a register re-runs the pass.
module nearest_scale_clip_address import nsca_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [32:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [11:0] pixel_x_i,
  input  logic [11:0] pixel_y_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        drawn_o,
  output logic [11:0] sample_x_o,
  output logic [11:0] sample_y_o,
  output logic [23:0] sample_address_o
);

  geo_t geo;
  logic busy, en, acc;

  nsca_setup u_setup (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .busy_o      (busy),
    .geo_o       (geo)
  );

  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = busy || !en;
  assign acc        = in_valid_i && !in_stall_o;

  // stage A: span test and offset into the destination region
  logic signed [16:0] dx, dy;
  logic               in_x, in_y;
  logic               a_vld_q, a_ok_q;
  logic [14:0]        a_nx_q, a_ny_q;

  always_comb begin
    dx   = $signed({5'b0, pixel_x_i}) - geo.x.dpos;
    dy   = $signed({5'b0, pixel_y_i}) - geo.y.dpos;
    in_x = ({1'b0, pixel_x_i} >= geo.x.lo) && ({1'b0, pixel_x_i} < geo.x.hi);
    in_y = ({1'b0, pixel_y_i} >= geo.y.lo) && ({1'b0, pixel_y_i} < geo.y.hi);
  end

  // stage B: offset times source extent
  logic                 b_vld_q, b_ok_q;
  logic [PROD_BITS-1:0] b_px_q, b_py_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
    end else if (en) begin
      a_vld_q <= acc;
      b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_ok_q <= geo.ok && in_x && in_y;
      a_nx_q <= dx[14:0];
      a_ny_q <= dy[14:0];
      b_ok_q <= a_ok_q;
      b_px_q <= PROD_BITS'(a_nx_q) * PROD_BITS'(geo.x.sext);
      b_py_q <= PROD_BITS'(a_ny_q) * PROD_BITS'(geo.y.sext);
    end
  end

  div_cell_t chain [DIV_STEPS+1];

  always_comb begin
    chain[0].vld   = b_vld_q;
    chain[0].ok    = b_ok_q;
    chain[0].rem_x = b_px_q;
    chain[0].quo_x = '0;
    chain[0].rem_y = b_py_q;
    chain[0].quo_y = '0;
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_cell
    logic [PROD_BITS-1:0] den_x, den_y;
    assign den_x = PROD_BITS'(geo.x.dext) << (DIV_STEPS - 1 - k);
    assign den_y = PROD_BITS'(geo.y.dext) << (DIV_STEPS - 1 - k);

    nsca_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .den_x_i (den_x),
      .den_y_i (den_y),
      .cell_i  (chain[k]),
      .cell_o  (chain[k+1])
    );
  end

  // stage F1: add source origin, stage F2: linear address
  div_cell_t   last;
  logic        f1_vld_q, f1_ok_q;
  logic [11:0] f1_sx_q, f1_sy_q;
  logic [11:0] sx_sum, sy_sum;
  logic [24:0] row_base;
  logic        out_vld_q, drawn_q;
  logic [11:0] sx_q, sy_q;
  logic [23:0] addr_q;

  always_comb begin
    last     = chain[DIV_STEPS];
    sx_sum   = last.quo_x + geo.x.spos;
    sy_sum   = last.quo_y + geo.y.spos;
    row_base = 25'(f1_sy_q) * 25'(geo.src_w);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      f1_vld_q  <= last.vld;
      out_vld_q <= f1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f1_ok_q <= last.ok;
      f1_sx_q <= last.ok ? sx_sum : '0;
      f1_sy_q <= last.ok ? sy_sum : '0;
      drawn_q <= f1_ok_q;
      sx_q    <= f1_sx_q;
      sy_q    <= f1_sy_q;
      addr_q  <= row_base[23:0] + {12'b0, f1_sx_q};
    end
  end

  assign out_valid_o      = out_vld_q;
  assign drawn_o          = drawn_q;
  assign sample_x_o       = sx_q;
  assign sample_y_o       = sy_q;
  assign sample_address_o = addr_q;

`ifndef SYNTHESIS
  a_busy_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> in_stall_o)
    else $error("item taken during geometry pass");

  a_cfg_starts_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> busy)
    else $error("config write did not start geometry pass");

  a_undrawn_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !drawn_o) |->
      (sample_x_o == 12'd0 && sample_y_o == 12'd0 && sample_address_o == 24'd0))
    else $error("undrawn item carries nonzero sample");
`endif

endmodule

@@ bench/tb_top.sv @@
module tb_top;
  import nsca_pkg::*;

  typedef struct {
    logic [11:0] x;
    logic [11:0] y;
  } pixel_t;

  typedef struct {
    logic        drawn;
    logic [11:0] sx;
    logic [11:0] sy;
    logic [23:0] addr;
  } sample_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [32:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [11:0] pixel_x = '0;
  logic [11:0] pixel_y = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        drawn;
  logic [11:0] sample_x;
  logic [11:0] sample_y;
  logic [23:0] sample_address;

  nearest_scale_clip_address dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .pixel_x_i       (pixel_x),
    .pixel_y_i       (pixel_y),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .drawn_o         (drawn),
    .sample_x_o      (sample_x),
    .sample_y_o      (sample_y),
    .sample_address_o(sample_address)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  logic [32:0] geo_regs [8];
  logic [32:0] next_regs [8];
  pixel_t      pixel_queue [$];
  sample_t     sample_queue [$];
  int          n_in, n_out, n_drawn, n_phases, n_errors;
  int          burst_left, gap_left;
  int          hold_left, stall_cyc, stall_mode;
  bit          hold_go, hold_done;

  function automatic longint coord_of(input logic [15:0] h);
    return longint'($signed(h));
  endfunction

  function automatic longint dim_of(input logic [15:0] h);
    return (h > MAX_IMAGE_DIM) ? longint'(MAX_IMAGE_DIM) : longint'(h);
  endfunction

  function automatic bit meet(input longint a, aw, b, bw);
    return !((a + aw <= b) || (b + bw <= a));
  endfunction

  // one axis: effective span [lo, lo+len) and sanitized regions
  function automatic bit axis_span(input longint simg, dimg, input bit clip_on,
                                   input longint cp, ce, sp_i, se_i, dp_i, de_i,
                                   output longint lo, len, dp, de, sp, se);
    longint c, w, q;
    sp = sp_i; se = se_i; dp = dp_i; de = de_i; lo = 0; len = 0;
    if (de <= 0) return 0;
    if (!meet(dp, de, 0, dimg)) return 0;
    if (!meet(sp, se, 0, simg)) return 0;
    if (clip_on) begin
      c = cp; w = ce;
      if (c < 0) begin w += c; c = 0; end
      if (c + w > dimg) w = dimg - c;
    end else begin
      c = 0; w = dimg;
    end
    if (c < dp) begin w += c - dp; c = dp; end
    if (c + w > dp + de) w = dp + de - c;
    if (se <= 0 || w <= 0) return 0;
    if (sp < 0) begin
      q = (sp * de) / se;
      dp -= q; de += q; se += sp; sp = 0;
    end
    if (sp >= simg) return 0;
    if (sp + se > simg) begin
      de = (de * (simg - sp)) / se;
      se = simg - sp;
    end
    if (de <= 0 || se <= 0) return 0;
    if (c < 0) begin w += c; c = 0; end
    if (w <= 0 || c >= dimg) return 0;
    if (c < dp) begin w += c - dp; c = dp; end
    if (c + w > dimg) w = dimg - c;
    if (c + w > dp + de) w = dp + de - c;
    if (w <= 0) return 0;
    lo = c; len = w;
    return 1;
  endfunction

  function automatic sample_t scale_pixel(input logic [11:0] px, input logic [11:0] py);
    sample_t r;
    longint xlo, xlen, xdp, xde, xsp, xse, ylo, ylen, ydp, yde, ysp, yse, sx, sy, src_w;
    bit ok, clip_on;
    r = '{1'b0, '0, '0, '0};
    clip_on = geo_regs[REG_CLIP_EXT][32];
    src_w = dim_of(geo_regs[REG_SRC_SIZE][31:16]);
    ok = axis_span(src_w, dim_of(geo_regs[REG_DST_SIZE][31:16]), clip_on,
                   coord_of(geo_regs[REG_CLIP_ORG][31:16]),
                   coord_of(geo_regs[REG_CLIP_EXT][31:16]),
                   coord_of(geo_regs[REG_SRC_ORG][31:16]),
                   coord_of(geo_regs[REG_SRC_EXT][31:16]),
                   coord_of(geo_regs[REG_DST_ORG][31:16]),
                   coord_of(geo_regs[REG_DST_EXT][31:16]),
                   xlo, xlen, xdp, xde, xsp, xse);
    if (ok)
      ok = axis_span(dim_of(geo_regs[REG_SRC_SIZE][15:0]),
                     dim_of(geo_regs[REG_DST_SIZE][15:0]), clip_on,
                     coord_of(geo_regs[REG_CLIP_ORG][15:0]),
                     coord_of(geo_regs[REG_CLIP_EXT][15:0]),
                     coord_of(geo_regs[REG_SRC_ORG][15:0]),
                     coord_of(geo_regs[REG_SRC_EXT][15:0]),
                     coord_of(geo_regs[REG_DST_ORG][15:0]),
                     coord_of(geo_regs[REG_DST_EXT][15:0]),
                     ylo, ylen, ydp, yde, ysp, yse);
    if (ok && px >= xlo && px < xlo + xlen && py >= ylo && py < ylo + ylen) begin
      sx = ((longint'(px) - xdp) * xse) / xde + xsp;
      sy = ((longint'(py) - ydp) * yse) / yde + ysp;
      r.drawn = 1'b1;
      r.sx = sx[11:0];
      r.sy = sy[11:0];
      r.addr = 24'(sy * src_w + sx);
    end
    return r;
  endfunction

  // sender: bursts of random length with random gaps
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && !in_stall) begin
        sample_queue.push_back(scale_pixel(pixel_x, pixel_y));
        void'(pixel_queue.pop_front());
        n_in++;
      end
      if (in_valid && in_stall) begin
        // hold the stalled item
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pixel_queue.size() > 0) begin
        in_valid <= 1'b1;
        pixel_x <= pixel_queue[0].x;
        pixel_y <= pixel_queue[0].y;
        if (burst_left > 0) burst_left--;
        else begin
          burst_left = $urandom_range(0, 40);
          gap_left = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 9) : 0;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern redrawn at random among four modes, plus one long hold-off
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid && !out_stall) begin
        n_out++;
        if (sample_queue.size() == 0) begin
          n_errors++;
          if (n_errors <= 10) $display("unexpected result item at %0t", $realtime);
        end else begin
          sample_t e;
          e = sample_queue.pop_front();
          if (drawn !== e.drawn || sample_x !== e.sx || sample_y !== e.sy ||
              sample_address !== e.addr) begin
            n_errors++;
            if (n_errors <= 10)
              $display("mismatch: exp drawn=%0b x=%0d y=%0d addr=%0d, got %0b %0d %0d %0d",
                       e.drawn, e.sx, e.sy, e.addr, drawn, sample_x, sample_y,
                       sample_address);
          end
          if (e.drawn) n_drawn++;
        end
      end
      stall_cyc++;
      if (stall_cyc % 64 == 0) stall_mode = $urandom_range(0, 3);
      if (hold_go && !hold_done) begin
        hold_left = 400;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (stall_mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= stall_cyc[0];
        endcase
      end
    end
  end

  function automatic logic [32:0] pk(input int a, input int b);
    return {1'b0, a[15:0], b[15:0]};
  endfunction

  task automatic wait_idle();
    wait (pixel_queue.size() == 0 && sample_queue.size() == 0 && !in_valid);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic load_geometry();
    cfg_reg_e r;
    wait_idle();
    for (int i = 0; i < 8; i++) begin
      r = cfg_reg_e'(i);
      @(posedge clk_i);
      cfg_we <= 1'b1;
      cfg_index <= r;
      cfg_data <= next_regs[i];
      geo_regs[i] = (r == REG_CLIP_EXT) ? next_regs[i] : {1'b0, next_regs[i][31:0]};
    end
    @(posedge clk_i);
    cfg_we <= 1'b0;
    n_phases++;
  endtask

  task automatic push_pixel(input int x, input int y);
    pixel_queue.push_back('{x[11:0], y[11:0]});
  endtask

  function automatic int rand_dim();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return 4096;
      2: return 65535;
      3: return $urandom_range(4097, 65535);
      default: return $urandom_range(1, 80);
    endcase
  endfunction

  function automatic int rand_org(input int d);
    int m;
    m = (d > 4096) ? 4096 : d;
    case ($urandom_range(0, 7))
      0: return $urandom();
      1: return -$urandom_range(1, m + 8);
      2: return 0;
      default: return $urandom_range(0, m + 4);
    endcase
  endfunction

  function automatic int rand_ext(input int d);
    int m;
    m = (d > 4096) ? 4096 : d;
    case ($urandom_range(0, 7))
      0: return $urandom();
      1: return -$urandom_range(0, 5);
      default: return $urandom_range(1, m + 16);
    endcase
  endfunction

  initial begin
    int sw, sh, dw, dh, x, y;
    foreach (geo_regs[i]) geo_regs[i] = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset geometry: nothing drawn
    push_pixel(0, 0); push_pixel(4095, 4095); push_pixel(5, 7);

    // plain 2x upscale, clip off
    next_regs = '{pk(16, 16), pk(32, 32), pk(0, 0), pk(16, 16), pk(0, 0), pk(32, 32),
                  pk(0, 0), pk(0, 0)};
    load_geometry();
    push_pixel(0, 0); push_pixel(31, 31); push_pixel(32, 0); push_pixel(0, 32);
    push_pixel(17, 9); push_pixel(4095, 0); push_pixel(1, 30); push_pixel(2048, 2048);

    // negative source origin with clip enabled
    next_regs = '{pk(20, 20), pk(40, 40), pk(-6, -3), pk(20, 20), pk(2, 1), pk(30, 30),
                  pk(-5, 4), {1'b1, 16'(30), 16'(20)}};
    load_geometry();
    push_pixel(2, 1); push_pixel(10, 4); push_pixel(24, 23); push_pixel(31, 24);
    push_pixel(0, 10);

    // overhanging source region, clip past the shrunk region
    next_regs = '{pk(10, 12), pk(64, 64), pk(4, 6), pk(12, 12), pk(0, 0), pk(48, 48),
                  pk(10, 10), {1'b1, 16'(60), 16'(60)}};
    load_geometry();
    push_pixel(10, 10); push_pixel(23, 23); push_pixel(24, 24); push_pixel(30, 12);
    push_pixel(47, 47);

    // all fields at maximum
    foreach (next_regs[i]) next_regs[i] = '1;
    load_geometry();
    push_pixel(0, 0); push_pixel(4095, 4095); push_pixel(100, 3000);

    // large images, full span
    next_regs = '{pk(4096, 4096), pk(65535, 65535), pk(0, 0), pk(4096, 4096), pk(0, 0),
                  pk(4096, 4096), pk(0, 0), pk(0, 0)};
    load_geometry();
    push_pixel(4095, 4095); push_pixel(0, 4095);

    while (n_in + pixel_queue.size() < 2000) begin
      sw = rand_dim(); sh = rand_dim(); dw = rand_dim(); dh = rand_dim();
      next_regs[REG_SRC_SIZE] = pk(sw, sh);
      next_regs[REG_DST_SIZE] = pk(dw, dh);
      next_regs[REG_SRC_ORG] = pk(rand_org(sw), rand_org(sh));
      next_regs[REG_SRC_EXT] = pk(rand_ext(sw), rand_ext(sh));
      next_regs[REG_DST_ORG] = pk(rand_org(dw), rand_org(dh));
      next_regs[REG_DST_EXT] = pk(rand_ext(dw), rand_ext(dh));
      next_regs[REG_CLIP_ORG] = pk(rand_org(dw), rand_org(dh));
      next_regs[REG_CLIP_EXT] = {1'($urandom_range(0, 1)), pk(rand_ext(dw), rand_ext(dh))};
      load_geometry();
      if (n_phases == 12) hold_go = 1'b1;
      repeat (60) begin
        if ($urandom_range(0, 5) == 0) begin
          x = $urandom_range(0, 4095); y = $urandom_range(0, 4095);
        end else begin
          x = $urandom_range(0, (dw > 4095 ? 4095 : dw + 2));
          y = $urandom_range(0, (dh > 4095 ? 4095 : dh + 2));
        end
        push_pixel(x, y);
      end
    end

    wait_idle();
    repeat (30) @(posedge clk_i);
    $display("%0d pixels sent, %0d results checked (%0d drawn) over %0d geometry settings",
             n_in, n_out, n_drawn, n_phases);
    if (n_errors == 0 && sample_queue.size() == 0)
      $display("** nearest_scale_clip_address: PASSED **");
    else
      $display("** nearest_scale_clip_address: FAILED **");
    $finish;
  end

  initial begin
    #8_000_000;
    $display("timeout with %0d results outstanding", sample_queue.size());
    $display("** nearest_scale_clip_address: FAILED **");
    $finish;
  end

endmodule
